@@ sv/pcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Column post decoder package
// Shared types and constants for the column-post picture decoder.
// ----------------------------------------------------------------------------
package pcpd_pkg;

    // Default parameter values.
    localparam int DEFAULT_COLUMN_STRIDE = 200;
    localparam int DEFAULT_MAX_COLUMNS   = 320;

    // Reset value of the picture width register.
    localparam logic [8:0] WIDTH_RESET = 9'd320;

    // Top row byte that closes a column.
    localparam logic [7:0] END_MARK = 8'hFF;

    // Parse phase codes.
    localparam logic [2:0] PH_TOP  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_PAD1 = 3'd2;
    localparam logic [2:0] PH_PIX  = 3'd3;
    localparam logic [2:0] PH_PAD2 = 3'd4;

    // Result kinds.
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  pixel_index;
        logic [8:0]  column;
        logic        picture_done;
    } out_t;

    // Decoder state carried between transactions.
    typedef struct packed {
        logic [2:0]  phase;
        logic [8:0]  column_count;
        logic [15:0] column_base;
        logic [8:0]  current_row;
        logic [7:0]  pixels_left;
        logic        finished;
    } state_t;

endpackage

@@ sv/pcpd_step.sv @@
// ----------------------------------------------------------------------------
// Column post decoder step
// Combinational next-state and result logic for one data byte.
// ----------------------------------------------------------------------------
module pcpd_step #(
    parameter int COLUMN_STRIDE = pcpd_pkg::DEFAULT_COLUMN_STRIDE,
    parameter int MAX_COLUMNS   = pcpd_pkg::DEFAULT_MAX_COLUMNS
) (
    input  pcpd_pkg::in_t    item,
    input  pcpd_pkg::state_t state,
    input  logic [8:0]       picture_width,
    output pcpd_pkg::state_t state_next,
    output logic             has_result,
    output pcpd_pkg::out_t   result
);

    localparam logic [8:0]  MAX_W  = 9'(MAX_COLUMNS);
    localparam logic [15:0] STRIDE = 16'(COLUMN_STRIDE);

    pcpd_pkg::state_t cur;
    logic [8:0]       eff_width;
    logic             last_column;
    logic [7:0]       left_dec;

    // A restart clears the picture before the byte is taken.
    always_comb
    begin
        cur = state;
        if (item.restart)
        begin
            cur = '0;
            cur.phase = pcpd_pkg::PH_TOP;
        end
    end

    // Clamp the configured width into the legal range.
    always_comb
    begin
        eff_width = picture_width;
        if (eff_width == 9'd0)
        begin
            eff_width = 9'd1;
        end
        if (eff_width > MAX_W)
        begin
            eff_width = MAX_W;
        end
    end

    assign last_column = ({1'b0, cur.column_count} + 10'd1) >= {1'b0, eff_width};
    assign left_dec    = cur.pixels_left - 8'd1;

    // Phase sequencing and result formation.
    always_comb
    begin
        state_next = cur;
        has_result = 1'b0;
        result     = '0;
        result.column = cur.column_count;
        if (!cur.finished)
        begin
            case (cur.phase)
                pcpd_pkg::PH_TOP:
                begin
                    if (item.data_byte == pcpd_pkg::END_MARK)
                    begin
                        has_result          = 1'b1;
                        result.kind         = pcpd_pkg::KIND_MARKER;
                        result.picture_done = last_column;
                        if (last_column)
                        begin
                            state_next.finished = 1'b1;
                        end
                        else
                        begin
                            state_next.column_count = cur.column_count + 9'd1;
                            state_next.column_base  = cur.column_base + STRIDE;
                        end
                    end
                    else
                    begin
                        state_next.current_row = {1'b0, item.data_byte};
                        state_next.phase       = pcpd_pkg::PH_LEN;
                    end
                end
                pcpd_pkg::PH_LEN:
                begin
                    state_next.pixels_left = item.data_byte;
                    state_next.phase       = pcpd_pkg::PH_PAD1;
                end
                pcpd_pkg::PH_PAD1:
                begin
                    state_next.phase = (cur.pixels_left != 8'd0) ? pcpd_pkg::PH_PIX
                                                                 : pcpd_pkg::PH_PAD2;
                end
                pcpd_pkg::PH_PIX:
                begin
                    has_result             = 1'b1;
                    result.kind            = pcpd_pkg::KIND_PIXEL;
                    result.address         = cur.column_base + {7'd0, cur.current_row};
                    result.pixel_index     = item.data_byte;
                    state_next.current_row = cur.current_row + 9'd1;
                    state_next.pixels_left = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        state_next.phase = pcpd_pkg::PH_PAD2;
                    end
                end
                default:
                begin
                    state_next.phase = pcpd_pkg::PH_TOP;
                end
            endcase
        end
    end

endmodule

@@ sv/patch_column_post_decoder.sv @@
// ----------------------------------------------------------------------------
// Column-post picture decoder
// Turns a column-post byte stream into pixel writes and column end markers.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel carries one data byte per transaction, with restart set
//   on the first byte of a new picture. The result channel carries a pixel
//   write (kind 0) or a column end marker (kind 1); the marker of the last
//   column has picture_done set, and later bytes give nothing until restart.
//   The phase update and the address add sit between the state registers
//   and the result register, so one transaction is accepted every cycle
//   while item_stall is low; each result is registered before it is valid.
//   A two-entry output buffer (result register plus skid register) lets one
//   more byte be taken while the receiver stalls; item_stall rises only once
//   the skid register holds a result. The picture width register is written
//   through write_enable and write_data; the user must do so only while the
//   block is idle, as the block does not enforce it. Reset sets the width to
//   320, clears the decoder state and empties the output buffer.
// ----------------------------------------------------------------------------
module patch_column_post_decoder #(
    parameter int COLUMN_STRIDE = pcpd_pkg::DEFAULT_COLUMN_STRIDE,
    parameter int MAX_COLUMNS   = pcpd_pkg::DEFAULT_MAX_COLUMNS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           write_enable,
    input  logic [8:0]     write_data,
    input  logic           item_valid,
    output logic           item_stall,
    input  pcpd_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_stall,
    output pcpd_pkg::out_t result
);

    logic [8:0]       width_reg;
    pcpd_pkg::state_t state_reg;
    pcpd_pkg::state_t state_next;
    logic             step_has_result;
    pcpd_pkg::out_t   step_result;
    logic             out_valid_reg;
    pcpd_pkg::out_t   out_reg;
    logic             skid_valid_reg;
    pcpd_pkg::out_t   skid_reg;
    logic             item_accept;
    logic             result_fire;
    logic             new_result;

    assign item_stall   = skid_valid_reg;
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign result_fire  = out_valid_reg && !result_stall;
    assign new_result   = item_accept && step_has_result;

    // Picture width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= pcpd_pkg::WIDTH_RESET;
        end
        else if (write_enable)
        begin
            width_reg <= write_data;
        end
    end

    // Per-byte decode logic.
    pcpd_step #(
        .COLUMN_STRIDE (COLUMN_STRIDE),
        .MAX_COLUMNS   (MAX_COLUMNS)
    ) u_step (
        .item          (item),
        .state         (state_reg),
        .picture_width (width_reg),
        .state_next    (state_next),
        .has_result    (step_has_result),
        .result        (step_result)
    );

    // Decoder state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            state_reg.phase <= pcpd_pkg::PH_TOP;
        end
        else if (item_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output buffer valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= new_result;
            end
        end
        else if (new_result)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_result;
        end
        else if (new_result)
        begin
            skid_reg <= step_result;
        end
    end

    // The skid register only fills behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // Pixel writes never carry the picture done flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == pcpd_pkg::KIND_PIXEL) |-> !result.picture_done)
        else $error("pixel write marked as picture done");

    // Once finished, bytes without restart leave the state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && state_reg.finished && !item.restart) |=> $stable(state_reg))
        else $error("state changed after picture completion");

    // A filled skid register stops new transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall && new_result) |=> item_stall)
        else $error("input not stalled with a full output buffer");

endmodule
